@@ hdl/ial_pkg.sv @@
// Package for the indexed array list engine.
// Holds the operation and status codes, the controller state type and the default capacity.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int TALLY_W  = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_INDEX = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PLACE,
      S_DEL_READ,
      S_DEL_TALLY,
      S_SHIFT_DOWN,
      S_DONE
   } state_type;

endpackage : ial_pkg

`default_nettype wire

@@ hdl/indexed_array_list_engine_top.sv @@
// Indexed array list engine: top level with the element memory and its sequencer.
// Depends on ial_pkg for codes, the state type and the default capacity.
// Sequence: a query or a rejected operation goes straight to the done state; an insert
//   shifts entries up and places the value, a delete tallies the victim and shifts down.
// Throughput: one transaction at a time; busy stays high until the result is issued.
//   No result stall.
// Reset (synchronous, active high) empties the list and clears all tallies; the element
//   memory is not cleared, since only entries below the length are ever used.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_engine_top
   import ial_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Request channel.
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [MODE_W-1:0]          req_mode,
   input  wire logic [POS_W-1:0]           req_position,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   // Result channel.
   output logic                            rsp_valid,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [TALLY_W-1:0]              rsp_count,
   output logic [TALLY_W-1:0]              rsp_zeros,
   output logic [TALLY_W-1:0]              rsp_positives,
   output logic [TALLY_W-1:0]              rsp_negatives
);

   // Address width of the memory. The list holds at most CAPACITY-1 entries, so the
   // length and the tallies also fit in this many bits.
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   // Common width used when comparing the 8-bit position against the length.
   localparam int CMPW = (AW > POS_W) ? AW : POS_W;
   localparam logic [AW-1:0] OCC_MAX = AW'(CAPACITY - 1);

   // Element memory: one write port, one read port with a registered read.
   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;

   // Control and bookkeeping registers.
   state_type      state_ff, state_in;
   logic [AW-1:0]  occ_ff, occ_in;
   logic [AW-1:0]  zero_ff, zero_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [AW-1:0]  neg_ff, neg_in;
   logic [AW-1:0]  cursor_ff, cursor_in;
   logic           wr_pend_ff, wr_pend_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers, no reset needed.
   logic [AW-1:0]          index_ff, index_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [AW-1:0]          wr_addr_ff, wr_addr_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [TALLY_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [TALLY_W-1:0]     rsp_zeros_ff, rsp_zeros_in;
   logic [TALLY_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [TALLY_W-1:0]     rsp_neg_ff, rsp_neg_in;

   logic [CMPW-1:0] req_pos_ext;
   logic [CMPW-1:0] occ_ext;
   logic            accept;
   logic            val_zero;
   logic            val_neg;
   logic            old_zero;
   logic            old_neg;

   assign accept      = start && (state_ff == S_IDLE);
   assign req_pos_ext = CMPW'(req_position);
   assign occ_ext     = CMPW'(occ_ff);

   // Sign classes of the value being inserted and of the entry being deleted.
   assign val_zero = (value_ff == '0);
   assign val_neg  = value_ff[VALUE_W-1];
   assign old_zero = (rd_data_ff == '0);
   assign old_neg  = rd_data_ff[VALUE_W-1];

   // The memory write port either places the new value or completes a shift move
   // whose source word was read in the previous cycle.
   assign wr_en   = (state_ff == S_PLACE) || wr_pend_ff;
   assign wr_addr = (state_ff == S_PLACE) ? index_ff : wr_addr_ff;
   assign wr_data = (state_ff == S_PLACE) ? value_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         zero_ff      <= '0;
         pos_ff       <= '0;
         neg_ff       <= '0;
         cursor_ff    <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         zero_ff      <= zero_in;
         pos_ff       <= pos_in;
         neg_ff       <= neg_in;
         cursor_ff    <= cursor_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_zeros_ff  <= rsp_zeros_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_neg_ff    <= rsp_neg_in;
   end

   // Sequencer. An insert walks the cursor down from the length to the target index,
   // moving one word up per cycle; a delete first reads the victim for the tallies and
   // then walks the cursor up, moving one word down per cycle.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      zero_in       = zero_ff;
      pos_in        = pos_ff;
      neg_in        = neg_ff;
      cursor_in     = cursor_ff;
      wr_pend_in    = 1'b0;
      rsp_valid_in  = 1'b0;
      index_in      = index_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      wr_addr_in    = wr_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_zeros_in  = rsp_zeros_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_neg_in    = rsp_neg_ff;
      rd_addr       = cursor_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               index_in  = AW'(req_pos_ext);
               value_in  = req_value;
               status_in = STATUS_OK;
               state_in  = S_DONE;
               case (req_mode)
                  MODE_INSERT: begin
                     if (req_pos_ext > occ_ext) begin
                        status_in = STATUS_BAD_INDEX;
                     end else if (occ_ff == OCC_MAX) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cursor_in = occ_ff;
                        state_in  = S_SHIFT_UP;
                     end
                  end
                  MODE_DELETE: begin
                     if (req_pos_ext >= occ_ext) begin
                        status_in = STATUS_BAD_INDEX;
                     end else begin
                        state_in = S_DEL_READ;
                     end
                  end
                  default: begin
                     // Query, and the unused code, change nothing.
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            rd_addr = cursor_ff - AW'(1);
            if (cursor_ff > index_ff) begin
               wr_pend_in = 1'b1;
               wr_addr_in = cursor_ff;
               cursor_in  = cursor_ff - AW'(1);
            end else begin
               state_in = S_PLACE;
            end
         end

         S_PLACE: begin
            occ_in = occ_ff + AW'(1);
            if (val_zero) begin
               zero_in = zero_ff + AW'(1);
            end else if (val_neg) begin
               neg_in = neg_ff + AW'(1);
            end else begin
               pos_in = pos_ff + AW'(1);
            end
            state_in = S_DONE;
         end

         S_DEL_READ: begin
            rd_addr   = index_ff;
            cursor_in = index_ff;
            state_in  = S_DEL_TALLY;
         end

         S_DEL_TALLY: begin
            if (old_zero) begin
               if (zero_ff != '0) zero_in = zero_ff - AW'(1);
            end else if (old_neg) begin
               if (neg_ff != '0) neg_in = neg_ff - AW'(1);
            end else begin
               if (pos_ff != '0) pos_in = pos_ff - AW'(1);
            end
            state_in = S_SHIFT_DOWN;
         end

         S_SHIFT_DOWN: begin
            rd_addr = cursor_ff + AW'(1);
            if ((cursor_ff + AW'(1)) < occ_ff) begin
               wr_pend_in = 1'b1;
               wr_addr_in = cursor_ff;
               cursor_in  = cursor_ff + AW'(1);
            end else begin
               occ_in   = occ_ff - AW'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_count_in  = occ_ext[TALLY_W-1:0];
            rsp_zeros_in  = TALLY_W'(CMPW'(zero_ff));
            rsp_pos_in    = TALLY_W'(CMPW'(pos_ff));
            rsp_neg_in    = TALLY_W'(CMPW'(neg_ff));
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_zeros     = rsp_zeros_ff;
   assign rsp_positives = rsp_pos_ff;
   assign rsp_negatives = rsp_neg_ff;

   // The three tallies always account for every entry between operations.
   a_tally_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |->
         ((AW+2)'(zero_ff) + (AW+2)'(pos_ff) + (AW+2)'(neg_ff)) == (AW+2)'(occ_ff))
      else $error("tallies do not add up to the list length");

   // The list never holds more than CAPACITY-1 entries.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_MAX)
      else $error("list length beyond capacity");

   // Every finished operation issues exactly one single-cycle result.
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finished operation did not issue a result");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   // No memory write is left pending when the result goes out.
   a_no_pend_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> !wr_pend_ff)
      else $error("shift write still pending at completion");

endmodule : indexed_array_list_engine_top

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the indexed array list engine: directed and random transactions.
// A scoreboard class keeps its own copy of the list and predicts every reply at acceptance.
// Depends on ial_pkg and indexed_array_list_engine_top.
`timescale 1ns / 1ps

module tb_top;
   import ial_pkg::*;

   // The block is built with its default capacity, so the predictor uses the same figure.
   localparam int CAP = DEFAULT_CAPACITY;

   // Mode 3 has no name in the package; the block treats it as a query.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // The slowest correct run is 1619 transactions, each at worst a full shift and a sender
   // gap; the limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 2_000_000;

   // Cycles to keep watching after the last expected reply, about one full shift.
   localparam int DRAIN_CYCLES = CAP + 40;

   localparam int RANDOM_ITEMS = 1600;

   typedef struct {
      status_type         status;
      logic [TALLY_W-1:0] count;
      logic [TALLY_W-1:0] zeros;
      logic [TALLY_W-1:0] positives;
      logic [TALLY_W-1:0] negatives;
   } list_reply_type;

   // The scoreboard mirrors the list contents, the length and the three sign tallies. Each
   // accepted request updates the mirror and queues the reply the block must give for it.
   class list_ledger;
      logic signed [VALUE_W-1:0] entries [CAP];
      int length;
      int zero_n, pos_n, neg_n;
      list_reply_type awaited [$];
      int failures;
      int n_insert, n_delete, n_query, n_bad, n_full, peak, n_checked;

      function void adjust_tally(logic signed [VALUE_W-1:0] w, int delta);
         if (w == 0)
            zero_n += delta;
         else if (w < 0)
            neg_n += delta;
         else
            pos_n += delta;
      endfunction

      function void note_request(logic [MODE_W-1:0] op, logic [POS_W-1:0] idx,
                                 logic signed [VALUE_W-1:0] val);
         list_reply_type r;
         int at;
         int slot;
         at = idx;
         r.status = STATUS_OK;
         case (op)
            MODE_INSERT: begin
               n_insert++;
               // An index past the end is rejected before the full check.
               if (at > length)
                  r.status = STATUS_BAD_INDEX;
               else if (length + 1 >= CAP)
                  r.status = STATUS_FULL;
               else begin
                  for (slot = length; slot > at; slot--)
                     entries[slot] = entries[slot-1];
                  entries[at] = val;
                  length++;
                  adjust_tally(val, 1);
               end
            end
            MODE_DELETE: begin
               n_delete++;
               if (at >= length)
                  r.status = STATUS_BAD_INDEX;
               else begin
                  adjust_tally(entries[at], -1);
                  for (slot = at; slot + 1 < length; slot++)
                     entries[slot] = entries[slot+1];
                  length--;
               end
            end
            default: n_query++;
         endcase
         if (r.status == STATUS_BAD_INDEX)
            n_bad++;
         if (r.status == STATUS_FULL)
            n_full++;
         if (length > peak)
            peak = length;
         r.count     = TALLY_W'(length);
         r.zeros     = TALLY_W'(zero_n);
         r.positives = TALLY_W'(pos_n);
         r.negatives = TALLY_W'(neg_n);
         awaited.push_back(r);
      endfunction

      function void check_reply(logic [STATUS_W-1:0] status, logic [TALLY_W-1:0] count,
                                logic [TALLY_W-1:0] zeros, logic [TALLY_W-1:0] positives,
                                logic [TALLY_W-1:0] negatives);
         list_reply_type e;
         if (awaited.size() == 0) begin
            $error("unexpected reply: status %0d count %0d", status, count);
            failures++;
            return;
         end
         e = awaited.pop_front();
         n_checked++;
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            failures++;
         end
         if (count !== e.count) begin
            $error("count: expected %0d, actual %0d", e.count, count);
            failures++;
         end
         if (zeros !== e.zeros) begin
            $error("zeros: expected %0d, actual %0d", e.zeros, zeros);
            failures++;
         end
         if (positives !== e.positives) begin
            $error("positives: expected %0d, actual %0d", e.positives, positives);
            failures++;
         end
         if (negatives !== e.negatives) begin
            $error("negatives: expected %0d, actual %0d", e.negatives, negatives);
            failures++;
         end
      endfunction
   endclass

   // All inputs hold known values from time zero; reset starts asserted.
   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic [MODE_W-1:0]         req_mode = MODE_QUERY;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic [STATUS_W-1:0]       rsp_status;
   logic [TALLY_W-1:0]        rsp_count;
   logic [TALLY_W-1:0]        rsp_zeros;
   logic [TALLY_W-1:0]        rsp_positives;
   logic [TALLY_W-1:0]        rsp_negatives;

   list_ledger ledger = new();
   int cycle_count = 0;
   bit quiet_stretch = 1'b0;

   indexed_array_list_engine_top DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_zeros    (rsp_zeros),
      .rsp_positives(rsp_positives),
      .rsp_negatives(rsp_negatives)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Replies are sampled at the rising edge that ends their one strobe cycle. Reading right
   // after the edge sees the values from before it, since the block updates with NBAs.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_reply(rsp_status, rsp_count, rsp_zeros, rsp_positives, rsp_negatives);
   end

   // Watchdog: a hung handshake or a lost reply ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Presents one request and returns at the edge that accepts it, which is the edge where
   // start was high and busy low. The next request may be driven in the same time step, so
   // start stays high across back-to-back transactions without being lowered.
   task automatic issue_op(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] idx,
                           input logic signed [VALUE_W-1:0] val);
      req_mode     <= op;
      req_position <= idx;
      req_value    <= val;
      start        <= 1'b1;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      ledger.note_request(op, idx, val);
   endtask

   // About a quarter of the transactions are followed by an idle gap on the request side,
   // except in the quiet stretch. Varying gaps end at different points of a transaction.
   task automatic maybe_idle();
      int gap;
      if (!quiet_stretch && $urandom_range(0, 99) < 26) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Values lean toward the sign boundaries so that every tally moves often.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: return '0;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh8000_0000;
         3: return 32'(int'($urandom_range(0, 6)) - 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input logic [MODE_W-1:0] op, input int idx,
                       input logic signed [VALUE_W-1:0] val);
      issue_op(op, POS_W'(idx), val);
      maybe_idle();
   endtask

   initial begin
      int k;
      int r;
      int len;
      bit growing;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: operations on the empty list, inserts of every sign class, inserts and
      // deletes at front, middle and end, indices past the end for both, and the unused mode.
      send(MODE_QUERY, 0, 0);
      send(MODE_DELETE, 0, 0);                  // delete from an empty list
      send(MODE_INSERT, 1, 32'sd9);             // insert past the end of an empty list
      send(MODE_UNUSED, 0, 0);
      send(MODE_INSERT, 0, 0);
      send(MODE_INSERT, 1, 32'sh7FFF_FFFF);     // append
      send(MODE_INSERT, 0, 32'sh8000_0000);     // insert at the front
      send(MODE_INSERT, 1, -32'sd1);            // insert in the middle
      send(MODE_INSERT, 4, 32'sd1);             // append at index equal to the length
      send(MODE_INSERT, 255, 32'sd5);           // top index, far past the end
      send(MODE_DELETE, 5, 0);                  // index equal to the length
      send(MODE_DELETE, 255, 0);
      send(MODE_DELETE, 4, 0);                  // last entry
      send(MODE_DELETE, 0, 0);                  // first entry
      send(MODE_DELETE, 1, 0);                  // middle entry
      send(MODE_QUERY, 255, -32'sd1);           // position and value are ignored
      send(MODE_UNUSED, 255, 32'shFFFF_FFFF);
      send(MODE_INSERT, 2, 32'sh5555_5555);
      send(MODE_INSERT, 0, 32'shAAAA_AAAA);

      // Random part. The list swings between empty and full: a growing phase favors valid
      // inserts until the list is full and a random draw turns it around, a shrinking phase
      // favors valid deletes until the list is empty. About one transaction in ten is noise
      // with any mode, any index and any value, part of which gives out-of-range rejections.
      growing = 1'b1;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         quiet_stretch = (k >= 500 && k < 800);
         len = ledger.length;
         r = $urandom_range(0, 99);
         if (r < 10)
            send(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
         else if (r < 15)
            send(MODE_QUERY, $urandom_range(0, 255), $urandom);
         else if ((growing && r < 80) || (!growing && r >= 80))
            send(MODE_INSERT, $urandom_range(0, len), pick_value());
         else if (len > 0)
            send(MODE_DELETE, $urandom_range(0, len - 1), 0);
         else
            send(MODE_DELETE, $urandom_range(0, 3), 0);

         // Turn around at the ends; at the full end stay a little while to retry inserts.
         if (growing && ledger.length == CAP - 1 && $urandom_range(0, 3) == 0)
            growing = 1'b0;
         else if (!growing && ledger.length == 0)
            growing = 1'b1;
      end

      // Drain: wait for every reply, then watch a while longer for stray strobes.
      start <= 1'b0;
      while (ledger.awaited.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions (%0d inserts, %0d deletes, %0d queries), %0d replies",
               ledger.n_insert + ledger.n_delete + ledger.n_query, ledger.n_insert,
               ledger.n_delete, ledger.n_query, ledger.n_checked);
      $display("Rejected %0d as out of range and %0d as full; longest list held %0d entries",
               ledger.n_bad, ledger.n_full, ledger.peak);
      if (ledger.failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
